>>> hdl/tmwc_pkg.sv
// Shared types and constants for the tile map wall collision resolver.
// No dependencies; every other file imports this package.
package tmwc_pkg;

  localparam int POS_W  = 20;   // position fields, signed, 8 fraction bits
  localparam int TILE_W = 6;    // tile_x / tile_y fields
  localparam int CFG_W  = 7;    // map_width / map_height registers
  localparam int CFG_AW = 3;    // config byte address, registers at 0 and 4
  localparam int CFG_DW = 32;

  // Geometry in pixels. Tile span in 1/256 pixel must be a power of two.
  localparam int TILE_SIZE   = 32;
  localparam int ENTITY_SIZE = 32;
  localparam int TILE_SPAN   = TILE_SIZE * 256;
  localparam int SPAN_SHIFT  = $clog2(TILE_SPAN);
  localparam int ENT_SPAN    = ENTITY_SIZE * 256;
  localparam int ENT_HALF    = ENTITY_SIZE * 128;
  localparam int TILE_HALF   = TILE_SIZE * 128;
  localparam int REACH       = (ENTITY_SIZE + TILE_SIZE) * 128;

  // Corner coordinate, tile index taken from it, and running position.
  localparam int CRN_W  = POS_W + 1;
  localparam int TIDX_W = CRN_W - SPAN_SHIFT;
  localparam int ACC_W  = POS_W + 4;

  localparam int POS_MIN = -(2 ** (POS_W - 1));
  localparam int POS_MAX = (2 ** (POS_W - 1)) - 1;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  // paddr[2] selects the register
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [TILE_W-1:0]       tile_x;
    logic [TILE_W-1:0]       tile_y;
    logic                    solid;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } tmwc_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_pos_x;
    logic signed [POS_W-1:0] new_pos_y;
    logic                    hit;
  } tmwc_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] map_width;
    logic [CFG_W-1:0] map_height;
  } tmwc_cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LAST
  } tmwc_state_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] hi;
    lo = ACC_W'(POS_MIN);
    hi = ACC_W'(POS_MAX);
    if (v < lo) begin
      sat_pos = POS_W'(POS_MIN);
    end else if (v > hi) begin
      sat_pos = POS_W'(POS_MAX);
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

>>> hdl/tile_map_wall_collision_resolver_core.sv
// Tile map wall collision resolver: top level.
// Depends on tmwc_pkg, tmwc_cfg, tmwc_wall_ram and tmwc_resolve.
//
// Input channel: an item is taken on a clock edge with start high and busy
// low. command selects a tile write (tile_x, tile_y, solid) or a resolve of
// an entity position (pos_x, pos_y, signed, 8 fraction bits).
// A tile write gives no result; a write outside the MAP_MAX x MAP_MAX store is
// dropped. A resolve reads the four corner tiles from the wall memory, one per
// cycle, and applies each corner's push in the cycle after its read is issued.
// The result beat shows on out_valid/out_item for one cycle; busy is low again
// in that cycle. The pace of resolves is set by the four corner reads through
// the single read port, its registered read and the result register; a new
// item is taken only once the result shows.
// The receiver cannot hold off a result; it must take each beat as it shows.
// Configuration (map_width at 0x0, map_height at 0x4) is written over the
// APB-style port; the user must write it only while the block is idle, which
// the block does not enforce; pready is always high. After reset the block
// sweeps all MAP_MAX*MAP_MAX (4096 by default) wall memory entries clear, one
// per cycle, with busy high; configuration writes are taken during the sweep.
module tile_map_wall_collision_resolver_core #(
  parameter int MAP_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tmwc_pkg::tmwc_in_t          in_item,
  output logic                        out_valid,
  output tmwc_pkg::tmwc_out_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmwc_pkg::CFG_AW-1:0] paddr,
  input  logic [tmwc_pkg::CFG_DW-1:0] pwdata,
  output logic [tmwc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import tmwc_pkg::*;

  localparam int DEPTH = MAP_MAX * MAP_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tmwc_cfg_t     cfg;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  tmwc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmwc_wall_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_wall_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmwc_resolve #(
    .MAP_MAX (MAP_MAX),
    .AW      (AW)
  ) u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg       (cfg),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

>>> hdl/tmwc_cfg.sv
// APB-style register port for map_width and map_height.
// Depends on tmwc_pkg.
module tmwc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tmwc_pkg::CFG_AW-1:0] paddr,
  input  logic [tmwc_pkg::CFG_DW-1:0] pwdata,
  output logic [tmwc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output tmwc_pkg::tmwc_cfg_t        cfg
);
  import tmwc_pkg::*;

  logic [CFG_W-1:0] map_width_r;
  logic [CFG_W-1:0] map_height_r;
  logic [CFG_W-1:0] map_width_nxt;
  logic [CFG_W-1:0] map_height_nxt;

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MAP_WIDTH:  map_width_nxt  = pwdata[CFG_W-1:0];
        REG_MAP_HEIGHT: map_height_nxt = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= CFG_W'(64);
      map_height_r <= CFG_W'(64);
    end else begin
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAP_WIDTH:  prdata = CFG_DW'(map_width_r);
      REG_MAP_HEIGHT: prdata = CFG_DW'(map_height_r);
      default:        prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign cfg.map_width  = map_width_r;
  assign cfg.map_height = map_height_r;

endmodule

>>> hdl/tmwc_wall_ram.sv
// One-bit wall map memory: one write port, one read port, registered read.
// Depends on tmwc_pkg only for house consistency of imports.
module tmwc_wall_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  import tmwc_pkg::*;

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/tmwc_resolve.sv
// Command sequencer and push datapath: map clear, tile writes, corner reads
// and the per-corner position push. Depends on tmwc_pkg; drives tmwc_wall_ram.
module tmwc_resolve #(
  parameter int MAP_MAX = 64,
  parameter int AW      = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  tmwc_pkg::tmwc_in_t   in_item,
  input  tmwc_pkg::tmwc_cfg_t  cfg,
  output logic                 busy,
  output logic                 out_valid,
  output tmwc_pkg::tmwc_out_t  out_item,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic                 ram_wdata,
  output logic [AW-1:0]        ram_raddr,
  input  logic                 ram_rdata
);
  import tmwc_pkg::*;

  localparam int DEPTH = MAP_MAX * MAP_MAX;
  localparam int LIM_W = ($clog2(MAP_MAX + 1) > CFG_W) ? $clog2(MAP_MAX + 1) : CFG_W;
  localparam logic [LIM_W-1:0] MAP_MAX_L = LIM_W'(MAP_MAX);
  localparam logic [AW-1:0]    MAP_MAX_A = AW'(MAP_MAX);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [1:0]       K_LAST    = 2'd3;

  localparam logic signed [CRN_W-1:0] ENT_SPAN_C  = CRN_W'(ENT_SPAN);
  localparam logic signed [ACC_W-1:0] ENT_HALF_A  = ACC_W'(ENT_HALF);
  localparam logic signed [ACC_W-1:0] TILE_HALF_A = ACC_W'(TILE_HALF);
  localparam logic signed [ACC_W-1:0] REACH_A     = ACC_W'(REACH);
  // landing spots once pushed out: tile centre - entity half -/+ reach
  localparam logic signed [ACC_W-1:0] LAND_LO_A   = ACC_W'(TILE_HALF - ENT_HALF - REACH);
  localparam logic signed [ACC_W-1:0] LAND_HI_A   = ACC_W'(TILE_HALF - ENT_HALF + REACH);

  tmwc_state_t state_r, state_nxt;

  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [1:0]              k_r, k_nxt;
  logic                    pv_r, pv_nxt;
  logic [TIDX_W-2:0]       ptx_r, ptx_nxt;
  logic [TIDX_W-2:0]       pty_r, pty_nxt;
  logic signed [POS_W-1:0] px0_r, px0_nxt;
  logic signed [POS_W-1:0] py0_r, py0_nxt;
  logic signed [ACC_W-1:0] px_r, px_nxt;
  logic signed [ACC_W-1:0] py_r, py_nxt;
  logic                    hit_r, hit_nxt;
  logic                    out_valid_r, out_valid_nxt;
  tmwc_out_t               out_item_r, out_item_nxt;

  logic accept;
  logic clearing;
  logic walking;
  logic pushing;
  logic finishing;

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (start && in_item.command == CMD_RESOLVE) state_nxt = ST_READ;
      ST_READ:  if (k_r == K_LAST) state_nxt = ST_LAST;
      ST_LAST:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    clearing  = 1'b0;
    walking   = 1'b0;
    pushing   = 1'b0;
    finishing = 1'b0;
    case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_READ: begin
        walking = 1'b1;
        pushing = 1'b1;
      end
      ST_LAST: begin
        pushing   = 1'b1;
        finishing = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept = start && !busy;

  // ---------------- corner address ----------------
  logic signed [CRN_W-1:0]  cx, cy;
  logic signed [TIDX_W-1:0] ix, iy;
  logic [TIDX_W-2:0]        ix_u, iy_u;
  logic [LIM_W-1:0]         lim_w, lim_h;
  logic                     crn_in_rng;

  always_comb begin
    cx = {px0_r[POS_W-1], px0_r} + (k_r[0] ? ENT_SPAN_C : '0);
    cy = {py0_r[POS_W-1], py0_r} + (k_r[1] ? ENT_SPAN_C : '0);
    // floor division by the tile span
    ix   = cx[CRN_W-1:SPAN_SHIFT];
    iy   = cy[CRN_W-1:SPAN_SHIFT];
    ix_u = ix[TIDX_W-2:0];
    iy_u = iy[TIDX_W-2:0];
    lim_w = (LIM_W'(cfg.map_width) > MAP_MAX_L) ? MAP_MAX_L : LIM_W'(cfg.map_width);
    lim_h = (LIM_W'(cfg.map_height) > MAP_MAX_L) ? MAP_MAX_L : LIM_W'(cfg.map_height);
    crn_in_rng = !ix[TIDX_W-1] && !iy[TIDX_W-1] &&
                 (LIM_W'(ix_u) < lim_w) && (LIM_W'(iy_u) < lim_h);
  end

  assign ram_raddr = AW'(iy_u) * MAP_MAX_A + AW'(ix_u);

  // ---------------- write port: clear sweep or tile write ----------------
  logic wr_in_rng;

  assign wr_in_rng = (LIM_W'(in_item.tile_x) < MAP_MAX_L) &&
                     (LIM_W'(in_item.tile_y) < MAP_MAX_L);

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = accept && in_item.command == CMD_WRITE && wr_in_rng;
      ram_waddr = AW'(in_item.tile_y) * MAP_MAX_A + AW'(in_item.tile_x);
      ram_wdata = in_item.solid;
    end
  end

  assign clr_cnt_nxt = clearing ? clr_cnt_r + AW'(1) : clr_cnt_r;

  // ---------------- push datapath ----------------
  // Read data for corner k arrives in the cycle after its read, lined up with pv_r/ptx_r/pty_r.
  logic signed [ACC_W-1:0] tbx, tby, dx, dy, adx, ady;
  logic                    wall_hit, do_push;

  always_comb begin
    tbx = $signed(ACC_W'(ptx_r) << SPAN_SHIFT);
    tby = $signed(ACC_W'(pty_r) << SPAN_SHIFT);
    dx  = px_r + ENT_HALF_A - (tbx + TILE_HALF_A);
    dy  = py_r + ENT_HALF_A - (tby + TILE_HALF_A);
    adx = dx[ACC_W-1] ? -dx : dx;
    ady = dy[ACC_W-1] ? -dy : dy;
    wall_hit = pushing && pv_r && ram_rdata;
    // both depths positive <=> both |d| below reach
    do_push  = wall_hit && (adx < REACH_A) && (ady < REACH_A);
  end

  always_comb begin
    k_nxt         = walking ? k_r + 2'd1 : 2'd0;
    pv_nxt        = walking && crn_in_rng;
    ptx_nxt       = ix_u;
    pty_nxt       = iy_u;
    px0_nxt       = px0_r;
    py0_nxt       = py0_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    hit_nxt       = hit_r;
    out_valid_nxt = finishing;
    out_item_nxt  = out_item_r;

    if (accept && in_item.command == CMD_RESOLVE) begin
      px0_nxt = in_item.pos_x;
      py0_nxt = in_item.pos_y;
      px_nxt  = {{(ACC_W - POS_W){in_item.pos_x[POS_W-1]}}, in_item.pos_x};
      py_nxt  = {{(ACC_W - POS_W){in_item.pos_y[POS_W-1]}}, in_item.pos_y};
      hit_nxt = 1'b0;
    end else begin
      if (wall_hit) begin
        hit_nxt = 1'b1;
      end
      if (do_push) begin
        // smaller x depth means larger |dx|; ties go to y
        if (adx > ady) begin
          px_nxt = tbx + (dx[ACC_W-1] ? LAND_LO_A : LAND_HI_A);
        end else begin
          py_nxt = tby + (dy[ACC_W-1] ? LAND_LO_A : LAND_HI_A);
        end
      end
    end

    if (finishing) begin
      out_item_nxt.new_pos_x = sat_pos(px_nxt);
      out_item_nxt.new_pos_y = sat_pos(py_nxt);
      out_item_nxt.hit       = hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      pv_r        <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      k_r         <= k_nxt;
      pv_r        <= pv_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptx_r      <= ptx_nxt;
    pty_r      <= pty_nxt;
    px0_r      <= px0_nxt;
    py0_r      <= py0_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
